// ===== rtl/erwm_pkg.sv =====
// shared constants, types and helpers of the event rate window meter
package erwm_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W        = CNT_W + 1;

    localparam int CMD_W    = 2;
    localparam int STAMP_W  = 64;
    localparam int RATE_W   = 48;
    localparam int PERIOD_W = 32;
    localparam int STATUS_W = 2;
    localparam int WIN_W    = 7;
    localparam int FREQ_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int DIV_W    = 64;
    localparam int CMP_W    = (CNT_W > WIN_W) ? CNT_W : WIN_W;

    localparam int US_PER_S     = 1000000;
    localparam int US_W         = 20;
    localparam int QM_W         = PERIOD_W + 1;
    localparam int RM_W         = FREQ_W + US_W;
    localparam int PERIOD_Q_MAX = 4294;
    localparam int Q_W          = 13;

    localparam logic [WIN_W-1:0]  WINDOW_RESET = WIN_W'(64);
    localparam logic [FREQ_W-1:0] FREQ_RESET   = FREQ_W'(10000000);
    localparam logic [RATE_W-1:0]   RATE_MAX   = '1;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DROP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FEW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BACK = 2'd3;

    localparam logic CFG_WINDOW = 1'b0;
    localparam logic CFG_FREQ   = 1'b1;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DIV_W-1:0] rem;
    } t_div_res;

    // ring position base + off, wrapped at the window depth
    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                    input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(off);
        if (s >= SUM_W'(WINDOW_DEPTH)) begin
            s = s - SUM_W'(WINDOW_DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

endpackage

// ===== rtl/erwm_ram.sv =====
// generic single-port-write ram with registered read
module erwm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/erwm_div.sv =====
// serial restoring divider, one quotient bit per cycle
module erwm_div import erwm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output t_div_res         o_res
);

    localparam int STEP_W = $clog2(DIV_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0]  r_quot, n_quot;
    logic [DIV_W-1:0]  r_rem, n_rem;
    logic [DIV_W-1:0]  r_div, n_div;
    logic [DIV_W:0]    partial;
    logic [DIV_W:0]    diff;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_div   = r_div;
        partial = {r_rem, r_quot[DIV_W-1]};
        diff    = partial - {1'b0, r_div};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quot = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem  = diff[DIV_W] ? partial[DIV_W-1:0] : diff[DIV_W-1:0];
            n_quot = {r_quot[DIV_W-2:0], ~diff[DIV_W]};
            n_cnt  = r_cnt + STEP_W'(1);
            if (r_cnt == STEP_W'(DIV_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_div  <= n_div;
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quot;
    assign o_res.rem  = r_rem;

endmodule

// ===== rtl/event_rate_window_meter.sv =====
// event rate window meter top level: timestamp ring, query sequencer, output register
//
// Input channel (i_valid/o_ready) takes one word: a command and a 64-bit timestamp.
// Add sample stores the timestamp in the ring, dropping the oldest entries past the
// window; drop removes the oldest entry; a query returns one output word
// (o_valid/i_ready) with rate_fx (UQ32.16 events per second), period_us and status.
// Add and drop are handled in the idle state. A query reads the oldest and newest
// stamps from the ring ram (states S_RD1 and S_RD2) and then runs up to four 64-bit
// divisions on one shared serial divider at one bit per cycle; after the read,
// divide, multiply and done steps the word is offered, o_ready returns with it and
// the divider sets the rate. Queries with too few samples, a backwards span or a
// zero mean finish early. One item is in work at a time; o_ready is high when idle.
// The output register holds a finished word while the receiver stalls; new add
// and drop words are taken meanwhile, and a later query waits at its end until
// the register is free. Configuration (i_cfg_valid/o_cfg_ready) is always ready:
// index 0 window length, index 1 counter frequency.
// Reset empties the window, restores window 64 and frequency 10000000 and clears
// o_valid; ring contents are not cleared.
module event_rate_window_meter import erwm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [STAMP_W-1:0]  i_timestamp,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [RATE_W-1:0]   o_rate_fx,
    output logic [PERIOD_W-1:0] o_period_us,
    output logic [STATUS_W-1:0] o_status,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [FREQ_W-1:0]   i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_RD1, S_RD2, S_DIV_MEAN, S_DIV_RATE, S_DIV_PER, S_MUL, S_DIV_FRAC, S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_oldest, n_oldest;
    logic [CNT_W-1:0]    r_fill, n_fill;
    logic [WIN_W-1:0]    r_window, n_window;
    logic [FREQ_W-1:0]   r_freq, n_freq;
    logic [STAMP_W-1:0]  r_stamp_old, n_stamp_old;
    logic [DIV_W-1:0]    r_mean, n_mean;
    logic [QM_W-1:0]     r_qm, n_qm;
    logic [RM_W-1:0]     r_rm, n_rm;
    logic                r_div_start, n_div_start;
    logic [DIV_W-1:0]    r_div_a, n_div_a;
    logic [DIV_W-1:0]    r_div_b, n_div_b;
    logic [RATE_W-1:0]   r_res_rate, n_res_rate;
    logic [PERIOD_W-1:0] r_res_period, n_res_period;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic                r_out_valid, n_out_valid;
    logic [RATE_W-1:0]   r_out_rate, n_out_rate;
    logic [PERIOD_W-1:0] r_out_period, n_out_period;
    logic [STATUS_W-1:0] r_out_status, n_out_status;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [STAMP_W-1:0]  ram_rdata;
    t_div_res            div_res;

    logic [CMP_W-1:0]    win_ext, limit, fill_ext;
    logic                over;
    logic [CNT_W-1:0]    keep;
    logic [ADDR_W-1:0]   add_oldest;
    logic [QM_W-1:0]     period_sum;
    logic                accept;

    erwm_ram #(
        .WIDTH(STAMP_W),
        .DEPTH(WINDOW_DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(i_timestamp),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    erwm_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_div_start),
        .i_dividend(r_div_a),
        .i_divisor (r_div_b),
        .o_res     (div_res)
    );

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;

    // window bookkeeping for add sample
    always_comb begin
        win_ext    = CMP_W'(r_window);
        limit      = (win_ext > CMP_W'(WINDOW_DEPTH)) ? CMP_W'(WINDOW_DEPTH) : win_ext;
        fill_ext   = CMP_W'(r_fill);
        over       = (fill_ext >= limit);
        keep       = over ? CNT_W'(limit - CMP_W'(1)) : r_fill;
        add_oldest = over ? ring_add(r_oldest, CNT_W'(fill_ext - limit + CMP_W'(1)))
                          : r_oldest;
        ram_waddr  = ring_add(add_oldest, keep);
        ram_we     = accept && (i_command == CMD_ADD) && (limit != '0);
        ram_raddr  = (r_state == S_RD1) ? ring_add(r_oldest, r_fill - CNT_W'(1)) : r_oldest;
        period_sum = r_qm + QM_W'(div_res.quot[US_W-1:0]);
    end

    always_comb begin
        n_state      = r_state;
        n_oldest     = r_oldest;
        n_fill       = r_fill;
        n_window     = r_window;
        n_freq       = r_freq;
        n_stamp_old  = r_stamp_old;
        n_mean       = r_mean;
        n_qm         = r_qm;
        n_rm         = r_rm;
        n_div_start  = 1'b0;
        n_div_a      = r_div_a;
        n_div_b      = r_div_b;
        n_res_rate   = r_res_rate;
        n_res_period = r_res_period;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_rate   = r_out_rate;
        n_out_period = r_out_period;
        n_out_status = r_out_status;

        if (i_cfg_valid) begin
            if (i_cfg_index == CFG_WINDOW) begin
                n_window = i_cfg_data[WIN_W-1:0];
            end else begin
                n_freq = i_cfg_data;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_command)
                        CMD_ADD: begin
                            if (limit == '0) begin
                                n_fill = '0;
                            end else begin
                                n_oldest = add_oldest;
                                n_fill   = keep + CNT_W'(1);
                            end
                        end
                        CMD_DROP: begin
                            if (r_fill != '0) begin
                                n_oldest = ring_add(r_oldest, CNT_W'(1));
                                n_fill   = r_fill - CNT_W'(1);
                            end
                        end
                        CMD_QUERY: begin
                            if (r_fill < CNT_W'(2)) begin
                                n_res_rate   = '0;
                                n_res_period = '0;
                                n_res_status = ST_FEW;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_RD1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD1: begin
                n_stamp_old = ram_rdata;
                n_state     = S_RD2;
            end
            S_RD2: begin
                if (ram_rdata < r_stamp_old) begin
                    n_res_rate   = '0;
                    n_res_period = '0;
                    n_res_status = ST_BACK;
                    n_state      = S_DONE;
                end else begin
                    n_div_start = 1'b1;
                    n_div_a     = ram_rdata - r_stamp_old;
                    n_div_b     = DIV_W'(r_fill - CNT_W'(1));
                    n_state     = S_DIV_MEAN;
                end
            end
            S_DIV_MEAN: begin
                if (div_res.done) begin
                    if (div_res.quot == '0) begin
                        n_res_rate   = RATE_MAX;
                        n_res_period = '0;
                        n_res_status = ST_ZERO;
                        n_state      = S_DONE;
                    end else begin
                        n_mean      = div_res.quot;
                        n_div_start = 1'b1;
                        n_div_a     = DIV_W'({r_freq, FRAC_W'(0)});
                        n_div_b     = div_res.quot;
                        n_state     = S_DIV_RATE;
                    end
                end
            end
            S_DIV_RATE: begin
                if (div_res.done) begin
                    n_res_rate   = div_res.quot[RATE_W-1:0];
                    n_res_status = ST_OK;
                    if (r_freq == '0) begin
                        n_res_period = PERIOD_MAX;
                        n_state      = S_DONE;
                    end else begin
                        n_div_start = 1'b1;
                        n_div_a     = r_mean;
                        n_div_b     = DIV_W'(r_freq);
                        n_state     = S_DIV_PER;
                    end
                end
            end
            S_DIV_PER: begin
                if (div_res.done) begin
                    if (div_res.quot > DIV_W'(PERIOD_Q_MAX)) begin
                        n_res_period = PERIOD_MAX;
                        n_state      = S_DONE;
                    end else begin
                        n_qm    = QM_W'(div_res.quot[Q_W-1:0]) * QM_W'(US_PER_S);
                        n_rm    = RM_W'(div_res.rem[FREQ_W-1:0]) * RM_W'(US_PER_S);
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_div_start = 1'b1;
                n_div_a     = DIV_W'(r_rm);
                n_div_b     = DIV_W'(r_freq);
                n_state     = S_DIV_FRAC;
            end
            S_DIV_FRAC: begin
                if (div_res.done) begin
                    n_res_period = period_sum[QM_W-1] ? PERIOD_MAX : period_sum[PERIOD_W-1:0];
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_rate   = r_res_rate;
                    n_out_period = r_res_period;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_oldest    <= '0;
            r_fill      <= '0;
            r_window    <= WINDOW_RESET;
            r_freq      <= FREQ_RESET;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_oldest    <= n_oldest;
            r_fill      <= n_fill;
            r_window    <= n_window;
            r_freq      <= n_freq;
            r_div_start <= n_div_start;
            r_out_valid <= n_out_valid;
        end
        r_stamp_old  <= n_stamp_old;
        r_mean       <= n_mean;
        r_qm         <= n_qm;
        r_rm         <= n_rm;
        r_div_a      <= n_div_a;
        r_div_b      <= n_div_b;
        r_res_rate   <= n_res_rate;
        r_res_period <= n_res_period;
        r_res_status <= n_res_status;
        r_out_rate   <= n_out_rate;
        r_out_period <= n_out_period;
        r_out_status <= n_out_status;
    end

    assign o_valid     = r_out_valid;
    assign o_rate_fx   = r_out_rate;
    assign o_period_us = r_out_period;
    assign o_status    = r_out_status;

endmodule

// ===== rtl/erwm_checker.sv =====
// port-level checks of the event rate window meter, bound to the top level
module erwm_checker import erwm_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_ready,
    input logic [RATE_W-1:0]   o_rate_fx,
    input logic [PERIOD_W-1:0] o_period_us,
    input logic [STATUS_W-1:0] o_status
);

    // a stalled word stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output word dropped while stalled");

    a_few: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FEW) |-> (o_rate_fx == '0) && (o_period_us == '0))
        else $error("too few samples without zero outputs");

    a_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_BACK) |-> (o_rate_fx == '0) && (o_period_us == '0))
        else $error("backwards span without zero outputs");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_ZERO) |-> (o_rate_fx == RATE_MAX) && (o_period_us == '0))
        else $error("zero interval without saturated rate");

endmodule

bind event_rate_window_meter erwm_checker u_erwm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_rate_fx  (o_rate_fx),
    .o_period_us(o_period_us),
    .o_status   (o_status)
);
